@@ rtl/iev_pkg.sv @@
// Package for the isosurface edge vertex/normal pipeline.
// Holds field widths, register codes, the edge offset table and stage payload types.
// No dependencies.
`default_nettype none

package iev_pkg;

  localparam int ISO_W      = 24;
  localparam int MASK_W     = 16;
  localparam int ASP_W      = 16;
  localparam int EDGE_W     = 4;
  localparam int CELL_W     = 10;
  localparam int SMP_W      = 16;
  localparam int DIFF_W     = 17;
  localparam int VTX_W      = 23;
  localparam int NRM_W      = 16;
  localparam int G_W        = 33;   // scaled gradient, signed Q.8
  localparam int ND_W       = 26;   // crossing numerator/denominator, signed Q.8
  localparam int MN_W       = 24;   // normalized magnitude
  localparam int SQ_W       = 50;   // sum of squares
  localparam int LEN_W      = SQ_W / 2;
  localparam int NQ_W       = 15;   // normal quotient bits
  localparam int NRM_SH     = 14;   // Q1.14
  localparam int NORM_TOP   = 23;   // largest magnitude lands in [2^23, 2^24)
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int GRID_DIM_DEF    = 1024;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 12;

  localparam logic [ISO_W-1:0]  ISO_RST  = '0;
  localparam logic [MASK_W-1:0] MASK_RST = 16'hFFFF;
  localparam logic [ASP_W-1:0]  ASP_RST  = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ISO    = 2'd0,
    REG_MASK   = 2'd1,
    REG_ASPECT = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_e;

  typedef struct packed {
    logic [2:0] off;   // {z, y, x}
    axis_e      axis;
  } edge_info_t;

  // item state ahead of the crossing divider
  typedef struct packed {
    logic [2:0][CELL_W-1:0] crd;
    logic [EDGE_W-1:0]      edge_no;
    logic                   tz;
    logic                   to;
    logic [2:0][G_W-1:0]    ga;
    logic [2:0][G_W-1:0]    gb;
  } front_t;

  // position and signs carried along the normal path
  typedef struct packed {
    logic [2:0][VTX_W-1:0] vtx;
    logic [2:0]            sgn;
    logic                  zero;
  } side_t;

  typedef struct packed {
    side_t                side;
    logic [2:0][MN_W-1:0] mn;
  } back_t;

  typedef struct packed {
    logic [2:0][VTX_W-1:0] vtx;
    logic [2:0][NRM_W-1:0] nrm;
  } res_t;

  function automatic edge_info_t edge_info(input logic [EDGE_W-1:0] e);
    edge_info_t r;
    case (e)
      4'd0:    r = '{off: 3'b000, axis: AXIS_X};
      4'd1:    r = '{off: 3'b001, axis: AXIS_Y};
      4'd2:    r = '{off: 3'b010, axis: AXIS_X};
      4'd3:    r = '{off: 3'b000, axis: AXIS_Y};
      4'd4:    r = '{off: 3'b100, axis: AXIS_X};
      4'd5:    r = '{off: 3'b101, axis: AXIS_Y};
      4'd6:    r = '{off: 3'b110, axis: AXIS_X};
      4'd7:    r = '{off: 3'b100, axis: AXIS_Y};
      4'd8:    r = '{off: 3'b000, axis: AXIS_Z};
      4'd9:    r = '{off: 3'b001, axis: AXIS_Z};
      4'd10:   r = '{off: 3'b010, axis: AXIS_Z};
      4'd11:   r = '{off: 3'b011, axis: AXIS_Z};
      default: r = '{off: 3'b000, axis: AXIS_NONE};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/iev_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, tag carried alongside.
// Needs num_i < den_i * 2^Q_W. Standalone, no package.
`default_nettype none

module iev_div #(
  parameter int DEN_W = 25,
  parameter int Q_W   = 15,
  parameter int TAG_W = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [DEN_W+Q_W-1:0]   num_i,
  input  logic [DEN_W-1:0]       den_i,
  input  logic [TAG_W-1:0]       tag_i,
  output logic                   valid_o,
  output logic [Q_W-1:0]         quo_o,
  output logic [TAG_W-1:0]       tag_o
);

  localparam int N_W = DEN_W + Q_W;

  logic             vld_q [Q_W];
  logic [N_W-1:0]   rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];
  logic [TAG_W-1:0] tag_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int B = Q_W - 1 - k;
    logic             vld_p;
    logic [N_W-1:0]   rem_p;
    logic [N_W-1:0]   sub;
    logic [DEN_W-1:0] den_p;
    logic [Q_W-1:0]   quo_p;
    logic [Q_W-1:0]   quo_d;
    logic [TAG_W-1:0] tag_p;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_p = valid_i;
      assign rem_p = num_i;
      assign den_p = den_i;
      assign quo_p = '0;
      assign tag_p = tag_i;
    end else begin : g_next
      assign vld_p = vld_q[k-1];
      assign rem_p = rem_q[k-1];
      assign den_p = den_q[k-1];
      assign quo_p = quo_q[k-1];
      assign tag_p = tag_q[k-1];
    end

    assign sub = N_W'(den_p) << B;
    assign ge  = rem_p >= sub;

    always_comb begin
      quo_d    = quo_p;
      quo_d[B] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? (rem_p - sub) : rem_p;
        den_q[k] <= den_p;
        quo_q[k] <= quo_d;
        tag_q[k] <= tag_p;
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign tag_o   = tag_q[Q_W-1];

endmodule

`default_nettype wire

@@ rtl/iev_sqrt.sv @@
// Pipelined integer square root, one root bit per stage (bit-pair method).
// V_W must be even. Standalone, no package.
`default_nettype none

module iev_sqrt #(
  parameter int V_W   = 50,
  parameter int TAG_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [V_W-1:0]     val_i,
  input  logic [TAG_W-1:0]   tag_i,
  output logic               valid_o,
  output logic [V_W/2-1:0]   root_o,
  output logic [TAG_W-1:0]   tag_o
);

  localparam int S = V_W / 2;

  logic             vld_q [S];
  logic [V_W-1:0]   val_q [S];
  logic [V_W-1:0]   res_q [S];
  logic [TAG_W-1:0] tag_q [S];

  for (genvar k = 0; k < S; k++) begin : g_stage
    localparam logic [V_W-1:0] BIT = V_W'(1) << (V_W - 2 - 2 * k);
    logic             vld_p;
    logic [V_W-1:0]   val_p;
    logic [V_W-1:0]   res_p;
    logic [TAG_W-1:0] tag_p;
    logic [V_W:0]     trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_p = valid_i;
      assign val_p = val_i;
      assign res_p = '0;
      assign tag_p = tag_i;
    end else begin : g_next
      assign vld_p = vld_q[k-1];
      assign val_p = val_q[k-1];
      assign res_p = res_q[k-1];
      assign tag_p = tag_q[k-1];
    end

    assign trial = (V_W+1)'(res_p) + (V_W+1)'(BIT);
    assign ge    = (V_W+1)'(val_p) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        val_q[k] <= ge ? (val_p - trial[V_W-1:0]) : val_p;
        res_q[k] <= ge ? ((res_p >> 1) + BIT) : (res_p >> 1);
        tag_q[k] <= tag_p;
      end
    end
  end

  assign valid_o = vld_q[S-1];
  assign root_o  = res_q[S-1][S-1:0];
  assign tag_o   = tag_q[S-1];

endmodule

`default_nettype wire

@@ rtl/isosurface_edge_vertex_normal.sv @@
// Channel   Signals                                     Direction
// cfg       cfg_valid_i/cfg_ready_o, index, data        in
// in        in_valid_i/in_ready_o, edge, cell, samples  in
// out       out_valid_o/out_ready_i, vertex, normal     out
//
// One edge per cycle while no result waits in the skid register; the crossing divider has
// FRAC_BITS stages, the root 25 stages and the normal divider 15.
// Whole pipeline advances on one enable; a skid register behind the output register
// holds one result so in_ready_o is a flop and a request is taken while a result waits.
// Reset clears valid bits and the registers (iso 0, mask all ones, inv aspect 1.0).
// Depends on iev_pkg, iev_div, iev_sqrt.
`default_nettype none

module isosurface_edge_vertex_normal
  import iev_pkg::*;
#(
  parameter int GRID_DIM    = GRID_DIM_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [EDGE_W-1:0]       edge_number_i,
  input  logic [CELL_W-1:0]       cell_x_i,
  input  logic [CELL_W-1:0]       cell_y_i,
  input  logic [CELL_W-1:0]       cell_z_i,
  input  logic [SMP_W-1:0]        value_a_i,
  input  logic [SMP_W-1:0]        value_b_i,
  input  logic signed [DIFF_W-1:0] diff_ax_i,
  input  logic signed [DIFF_W-1:0] diff_ay_i,
  input  logic signed [DIFF_W-1:0] diff_az_i,
  input  logic signed [DIFF_W-1:0] diff_bx_i,
  input  logic signed [DIFF_W-1:0] diff_by_i,
  input  logic signed [DIFF_W-1:0] diff_bz_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [VTX_W-1:0]        vertex_x_o,
  output logic [VTX_W-1:0]        vertex_y_o,
  output logic [VTX_W-1:0]        vertex_z_o,
  output logic signed [NRM_W-1:0] nrm_x_o,
  output logic signed [NRM_W-1:0] nrm_y_o,
  output logic signed [NRM_W-1:0] nrm_z_o
);

  localparam int T_W  = FRAC_BITS + 1;
  localparam int P_W  = G_W + T_W + 1;
  localparam int M_W  = P_W + 1;
  localparam int PS_W = $clog2(M_W);
  localparam int GC_W = 17;
  localparam logic [GC_W-1:0]  GMAX  = GC_W'(GRID_DIM - 1);
  localparam logic [SMP_W-1:0] SMASK = SMP_W'((32'd1 << SAMPLE_BITS) - 32'd1);
  localparam logic [T_W-1:0]   T_ONE = T_W'(32'd1 << FRAC_BITS);
  localparam logic [PS_W-1:0]  TOP   = PS_W'(NORM_TOP);

  // ---------------- configuration ----------------
  logic [ISO_W-1:0]  iso_q;
  logic [MASK_W-1:0] mask_q;
  logic [ASP_W-1:0]  asp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iso_q  <= ISO_RST;
      mask_q <= MASK_RST;
      asp_q  <= ASP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ISO:    iso_q  <= cfg_data_i[ISO_W-1:0];
        REG_MASK:   mask_q <= cfg_data_i[MASK_W-1:0];
        REG_ASPECT: asp_q  <= cfg_data_i[ASP_W-1:0];
        default:    ;
      endcase
    end
  end

  // ---------------- global enable / output skid ----------------
  logic en;
  logic p_vld;
  res_t p_res;
  res_t out_q, skid_q;
  logic out_vld_q, skid_vld_q;

  assign en         = ~skid_vld_q;
  assign in_ready_o = en;

  // ---------------- stage 1: masks, crossing terms, z scale ----------------
  logic [SMP_W-1:0]        smask, sa, sb;
  logic signed [ND_W-1:0]  num_s, den_s, num_n, den_n;
  logic                    tz, to;
  front_t                  f_d, f_q;
  logic [ISO_W-1:0]        num1_q, den1_q;
  logic                    v1_q;
  logic signed [2*DIFF_W-1:0] gza, gzb;

  function automatic logic [CELL_W-1:0] sat_cell(input logic [CELL_W-1:0] c);
    if (GC_W'(c) > GMAX) return GMAX[CELL_W-1:0];
    return c;
  endfunction

  always_comb begin
    smask = mask_q & SMASK;
    sa    = value_a_i & smask;
    sb    = value_b_i & smask;
    num_s = $signed(ND_W'(iso_q)) - $signed(ND_W'({sa, 8'd0}));
    den_s = $signed(ND_W'({sb, 8'd0})) - $signed(ND_W'({sa, 8'd0}));
    num_n = den_s[ND_W-1] ? -num_s : num_s;
    den_n = den_s[ND_W-1] ? -den_s : den_s;
    tz    = (den_n == '0) || num_n[ND_W-1] || (num_n == '0);
    to    = !tz && (num_n >= den_n);
    gza   = (2*DIFF_W)'(diff_az_i) * (2*DIFF_W)'($signed({1'b0, asp_q}));
    gzb   = (2*DIFF_W)'(diff_bz_i) * (2*DIFF_W)'($signed({1'b0, asp_q}));
    f_d.crd     = {sat_cell(cell_z_i), sat_cell(cell_y_i), sat_cell(cell_x_i)};
    f_d.edge_no = edge_number_i;
    f_d.tz      = tz;
    f_d.to      = to;
    f_d.ga      = {gza[G_W-1:0], G_W'($signed({diff_ay_i, 8'd0})),
                   G_W'($signed({diff_ax_i, 8'd0}))};
    f_d.gb      = {gzb[G_W-1:0], G_W'($signed({diff_by_i, 8'd0})),
                   G_W'($signed({diff_bx_i, 8'd0}))};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q    <= f_d;
      num1_q <= (tz || to) ? '0 : num_n[ISO_W-1:0];
      den1_q <= den_n[ISO_W-1:0];
    end
  end

  // ---------------- crossing fraction divider ----------------
  logic                    td_vld;
  logic [FRAC_BITS-1:0]    td_quo;
  logic [$bits(front_t)-1:0] td_tag;

  iev_div #(
    .DEN_W (ISO_W),
    .Q_W   (FRAC_BITS),
    .TAG_W ($bits(front_t))
  ) u_tdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .num_i   ({num1_q, {FRAC_BITS{1'b0}}}),
    .den_i   (den1_q),
    .tag_i   (f_q),
    .valid_o (td_vld),
    .quo_o   (td_quo),
    .tag_o   (td_tag)
  );

  // ---------------- stage 2: vertex, blend products ----------------
  front_t                 ft;
  edge_info_t             ei;
  logic [T_W-1:0]         t_val, omt;
  logic [2:0][VTX_W-1:0]  vtx_d;
  logic signed [P_W-1:0]  pa_d [3];
  logic signed [P_W-1:0]  pb_d [3];
  logic signed [P_W-1:0]  pa2_q [3];
  logic signed [P_W-1:0]  pb2_q [3];
  logic [2:0][VTX_W-1:0]  vtx2_q;
  logic                   v2_q;

  always_comb begin
    ft    = front_t'(td_tag);
    ei    = edge_info(ft.edge_no);
    t_val = ft.tz ? '0 : (ft.to ? T_ONE : T_W'(td_quo));
    omt   = T_ONE - t_val;
    for (int i = 0; i < 3; i++) begin
      vtx_d[i] = VTX_W'((32'(ft.crd[i]) + 32'(ei.off[i])) << FRAC_BITS)
               + ((ei.axis == axis_e'(2'(i))) ? VTX_W'(t_val) : '0);
      pa_d[i]  = P_W'($signed(ft.ga[i])) * P_W'($signed({1'b0, omt}));
      pb_d[i]  = P_W'($signed(ft.gb[i])) * P_W'($signed({1'b0, t_val}));
    end
  end

  // ---------------- stages 3..8: sum, abs, max, lead, shift, squares ----------------
  logic signed [M_W-1:0] n3 [3];
  logic [2:0][M_W-1:0]   m3_d, m3_q, m4_q;
  logic [M_W-1:0]        mx_d, mx4_q;
  side_t                 s3_d, s3_q, s4_q, s5_q, s6_q, s7_q, s8_q;
  logic [PS_W-1:0]       pos_d, pos5_q;
  logic [2:0][M_W-1:0]   m5_q;
  logic [2:0][MN_W-1:0]  mn_d, mn6_q, mn7_q;
  logic [2:0][2*MN_W-1:0] sq7_q;
  logic [SQ_W-1:0]       sum8_q;
  logic [2:0][MN_W-1:0]  mn8_q;
  logic                  v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;

  always_comb begin
    s3_d.vtx  = vtx2_q;
    s3_d.zero = 1'b0;
    for (int i = 0; i < 3; i++) begin
      n3[i]       = M_W'(pa2_q[i]) + M_W'(pb2_q[i]);
      s3_d.sgn[i] = n3[i][M_W-1];
      m3_d[i]     = n3[i][M_W-1] ? M_W'(-n3[i]) : M_W'(n3[i]);
    end
    mx_d = (m3_q[0] > m3_q[1]) ? m3_q[0] : m3_q[1];
    if (m3_q[2] > mx_d) mx_d = m3_q[2];
    pos_d = '0;
    for (int j = 0; j < M_W; j++) begin
      if (mx4_q[j]) pos_d = PS_W'(j);
    end
    for (int i = 0; i < 3; i++) begin
      if (pos5_q >= TOP) mn_d[i] = MN_W'(m5_q[i] >> (pos5_q - TOP));
      else               mn_d[i] = MN_W'(m5_q[i] << (TOP - pos5_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en) begin
      v2_q <= td_vld;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vtx2_q <= vtx_d;
      for (int i = 0; i < 3; i++) begin
        pa2_q[i] <= pa_d[i];
        pb2_q[i] <= pb_d[i];
        sq7_q[i] <= (2*MN_W)'(mn6_q[i]) * (2*MN_W)'(mn6_q[i]);
      end
      s3_q      <= s3_d;
      m3_q      <= m3_d;
      s4_q      <= '{vtx: s3_q.vtx, sgn: s3_q.sgn, zero: (mx_d == '0)};
      m4_q      <= m3_q;
      mx4_q     <= mx_d;
      s5_q      <= s4_q;
      m5_q      <= m4_q;
      pos5_q    <= pos_d;
      s6_q      <= s5_q;
      mn6_q     <= mn_d;
      s7_q      <= s6_q;
      mn7_q     <= mn6_q;
      s8_q      <= s7_q;
      mn8_q     <= mn7_q;
      sum8_q    <= SQ_W'(sq7_q[0]) + SQ_W'(sq7_q[1]) + SQ_W'(sq7_q[2]);
    end
  end

  // ---------------- vector length ----------------
  logic                      sr_vld;
  logic [LEN_W-1:0]          sr_len;
  logic [$bits(back_t)-1:0]  sr_tag;
  back_t                     bk_in, bk;

  assign bk_in = '{side: s8_q, mn: mn8_q};

  iev_sqrt #(
    .V_W   (SQ_W),
    .TAG_W ($bits(back_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v8_q),
    .val_i   (sum8_q),
    .tag_i   (bk_in),
    .valid_o (sr_vld),
    .root_o  (sr_len),
    .tag_o   (sr_tag)
  );

  // ---------------- stage 9: rounded numerators ----------------
  localparam int NN_W = LEN_W + NQ_W;
  logic [LEN_W-1:0]          len1;
  logic [LEN_W-1:0]          len9_q;
  logic [2:0][NN_W-1:0]      nn9_q;
  side_t                     s9_q;
  logic                      v9_q;

  always_comb begin
    bk   = back_t'(sr_tag);
    len1 = (sr_len == '0) ? LEN_W'(1) : sr_len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q <= 1'b0;
    end else if (en) begin
      v9_q <= sr_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      len9_q <= len1;
      s9_q   <= bk.side;
      for (int i = 0; i < 3; i++) begin
        nn9_q[i] <= (NN_W'(bk.mn[i]) << NRM_SH) + NN_W'(len1 >> 1);
      end
    end
  end

  // ---------------- normal component dividers ----------------
  logic                      dx_vld, dy_vld, dz_vld;
  logic [NQ_W-1:0]           qx, qy, qz;
  logic [$bits(side_t)-1:0]  dx_tag;
  logic                      dy_sgn, dz_sgn;
  side_t                     sd;

  iev_div #(.DEN_W(LEN_W), .Q_W(NQ_W), .TAG_W($bits(side_t))) u_ndiv_x (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (v9_q),
    .num_i (nn9_q[0]), .den_i (len9_q), .tag_i (s9_q),
    .valid_o (dx_vld), .quo_o (qx), .tag_o (dx_tag)
  );

  iev_div #(.DEN_W(LEN_W), .Q_W(NQ_W), .TAG_W(1)) u_ndiv_y (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (v9_q),
    .num_i (nn9_q[1]), .den_i (len9_q), .tag_i (s9_q.sgn[1]),
    .valid_o (dy_vld), .quo_o (qy), .tag_o (dy_sgn)
  );

  iev_div #(.DEN_W(LEN_W), .Q_W(NQ_W), .TAG_W(1)) u_ndiv_z (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (v9_q),
    .num_i (nn9_q[2]), .den_i (len9_q), .tag_i (s9_q.sgn[2]),
    .valid_o (dz_vld), .quo_o (qz), .tag_o (dz_sgn)
  );

  always_comb begin
    sd        = side_t'(dx_tag);
    p_vld     = dx_vld;
    p_res.vtx = sd.vtx;
    p_res.nrm[0] = sd.zero ? '0 : (sd.sgn[0] ? -NRM_W'(qx) : NRM_W'(qx));
    p_res.nrm[1] = sd.zero ? '0 : (dy_sgn    ? -NRM_W'(qy) : NRM_W'(qy));
    p_res.nrm[2] = sd.zero ? '0 : (dz_sgn    ? -NRM_W'(qz) : NRM_W'(qz));
  end

  // ---------------- output register and skid ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_ready_i || !out_vld_q) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= p_vld;
      end
    end else if (p_vld && en) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_vld_q) begin
      out_q <= skid_vld_q ? skid_q : p_res;
    end else if (p_vld && en) begin
      skid_q <= p_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign vertex_x_o  = out_q.vtx[0];
  assign vertex_y_o  = out_q.vtx[1];
  assign vertex_z_o  = out_q.vtx[2];
  assign nrm_x_o     = out_q.nrm[0];
  assign nrm_y_o     = out_q.nrm[1];
  assign nrm_z_o     = out_q.nrm[2];

  // ---------------- checks ----------------
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dy_vld == dx_vld) && (dz_vld == dx_vld))
    else $error("normal dividers out of step");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !out_ready_i))
    else $error("skid filled without output stall");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(nrm_x_o) <= 16384 && $signed(nrm_x_o) >= -16384
                  && $signed(nrm_y_o) <= 16384 && $signed(nrm_y_o) >= -16384
                  && $signed(nrm_z_o) <= 16384 && $signed(nrm_z_o) >= -16384))
    else $error("normal component beyond unit");

endmodule

`default_nettype wire

@@ tb/isosurface_edge_vertex_normal_chk.sv @@
// Checker for the isosurface edge vertex/normal block: watches the config, edge
// and result channels, predicts each vertex and normal and compares them.
// Depends on iev_pkg for widths and register codes.
module isosurface_edge_vertex_normal_chk
  import iev_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [EDGE_W-1:0]        edge_number_i,
  input  logic [CELL_W-1:0]        cell_x_i,
  input  logic [CELL_W-1:0]        cell_y_i,
  input  logic [CELL_W-1:0]        cell_z_i,
  input  logic [SMP_W-1:0]         value_a_i,
  input  logic [SMP_W-1:0]         value_b_i,
  input  logic signed [DIFF_W-1:0] diff_ax_i,
  input  logic signed [DIFF_W-1:0] diff_ay_i,
  input  logic signed [DIFF_W-1:0] diff_az_i,
  input  logic signed [DIFF_W-1:0] diff_bx_i,
  input  logic signed [DIFF_W-1:0] diff_by_i,
  input  logic signed [DIFF_W-1:0] diff_bz_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [VTX_W-1:0]         vertex_x_i,
  input  logic [VTX_W-1:0]         vertex_y_i,
  input  logic [VTX_W-1:0]         vertex_z_i,
  input  logic [NRM_W-1:0]         nrm_x_i,
  input  logic [NRM_W-1:0]         nrm_y_i,
  input  logic [NRM_W-1:0]         nrm_z_i,
  output int                       err_cnt_o,
  output int                       pending_o,
  output int                       checked_o
);

  localparam int FB  = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;

  typedef struct {
    logic [VTX_W-1:0] vtx [3];
    logic [NRM_W-1:0] nrm [3];
  } vertex_normal_t;

  vertex_normal_t expected_vertices [$];

  logic [ISO_W-1:0]  iso_q;
  logic [MASK_W-1:0] mask_q;
  logic [ASP_W-1:0]  aspect_q;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bt;
    res = 0;
    bt  = longint'(1) << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic vertex_normal_t predict_vertex_normal(
      input logic [EDGE_W-1:0] e, input logic [CELL_W-1:0] cx, cy, cz,
      input logic [SMP_W-1:0] va, vb,
      input logic signed [DIFF_W-1:0] dax, day, daz, dbx, dby, dbz);
    vertex_normal_t r;
    longint a, b, num, den, t, c;
    longint ga [3];
    longint gb [3];
    longint n  [3];
    longint unsigned m [3];
    longint unsigned crd [3];
    longint unsigned mx, sum, len, v;
    logic [2:0] off;
    axis_e ax;
    a   = longint'(va & mask_q);
    b   = longint'(vb & mask_q);
    num = longint'(iso_q) - a * 256;
    den = (b - a) * 256;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (den == 0 || num <= 0) t = 0;
    else if (num >= den) t = ONE;
    else t = (num * ONE) / den;

    // off is {z, y, x}
    case (e)
      4'd0:    begin off = 3'b000; ax = AXIS_X; end
      4'd1:    begin off = 3'b001; ax = AXIS_Y; end
      4'd2:    begin off = 3'b010; ax = AXIS_X; end
      4'd3:    begin off = 3'b000; ax = AXIS_Y; end
      4'd4:    begin off = 3'b100; ax = AXIS_X; end
      4'd5:    begin off = 3'b101; ax = AXIS_Y; end
      4'd6:    begin off = 3'b110; ax = AXIS_X; end
      4'd7:    begin off = 3'b100; ax = AXIS_Y; end
      4'd8:    begin off = 3'b000; ax = AXIS_Z; end
      4'd9:    begin off = 3'b001; ax = AXIS_Z; end
      4'd10:   begin off = 3'b010; ax = AXIS_Z; end
      4'd11:   begin off = 3'b011; ax = AXIS_Z; end
      default: begin off = 3'b000; ax = AXIS_NONE; end
    endcase
    crd[0] = 64'(cx);
    crd[1] = 64'(cy);
    crd[2] = 64'(cz);
    for (int i = 0; i < 3; i++) begin
      if (crd[i] > 64'(GRID_DIM_DEF - 1)) crd[i] = 64'(GRID_DIM_DEF - 1);
      v = (crd[i] + 64'(off[i])) << FB;
      if (int'(ax) == i) v = v + longint'(t);
      r.vtx[i] = v[VTX_W-1:0];
    end

    ga[0] = longint'(dax) * 256;
    ga[1] = longint'(day) * 256;
    ga[2] = longint'(daz) * longint'(aspect_q);
    gb[0] = longint'(dbx) * 256;
    gb[1] = longint'(dby) * 256;
    gb[2] = longint'(dbz) * longint'(aspect_q);
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      n[i] = ga[i] * (ONE - t) + gb[i] * t;
      m[i] = (n[i] < 0) ? -n[i] : n[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) r.nrm[i] = '0;
      return r;
    end
    while (mx >= (longint'(1) << 24)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (longint'(1) << 23)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = int_sqrt(sum);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      c = longint'((m[i] * 16384 + (len >> 1)) / len);
      if (n[i] < 0) c = -c;
      r.nrm[i] = c[NRM_W-1:0];
    end
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned exp_v, act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_cnt_o++;
    end
  endtask

  initial begin
    err_cnt_o = 0;
    checked_o = 0;
  end

  assign pending_o = expected_vertices.size();

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_normal_t want;
    if (!rst_ni) begin
      iso_q    <= ISO_RST;
      mask_q   <= MASK_RST;
      aspect_q <= ASP_RST;
      expected_vertices.delete();
    end else begin
      // an edge taken on the same edge as a write still sees the old setting
      if (in_valid_i && in_ready_i)
        expected_vertices.push_back(predict_vertex_normal(edge_number_i,
            cell_x_i, cell_y_i, cell_z_i, value_a_i, value_b_i,
            diff_ax_i, diff_ay_i, diff_az_i, diff_bx_i, diff_by_i, diff_bz_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ISO:    iso_q    <= cfg_data_i[ISO_W-1:0];
          REG_MASK:   mask_q   <= cfg_data_i[MASK_W-1:0];
          REG_ASPECT: aspect_q <= cfg_data_i[ASP_W-1:0];
          default:    ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_vertices.size() == 0) begin
          $error("result with no pending request");
          err_cnt_o++;
        end else begin
          want = expected_vertices.pop_front();
          checked_o++;
          check_field("vertex_x", 64'(want.vtx[0]), 64'(vertex_x_i));
          check_field("vertex_y", 64'(want.vtx[1]), 64'(vertex_y_i));
          check_field("vertex_z", 64'(want.vtx[2]), 64'(vertex_z_i));
          check_field("nrm_x", 64'(want.nrm[0]), 64'(nrm_x_i));
          check_field("nrm_y", 64'(want.nrm[1]), 64'(nrm_y_i));
          check_field("nrm_z", 64'(want.nrm[2]), 64'(nrm_z_i));
        end
      end
    end
  end

endmodule

@@ tb/isosurface_edge_vertex_normal_tb.sv @@
// Top of the isosurface edge vertex/normal testbench: clock, reset, register
// writes, directed and random edges, output back-pressure and the verdict.
// Depends on iev_pkg, the block and isosurface_edge_vertex_normal_chk.
module isosurface_edge_vertex_normal_tb;
  import iev_pkg::*;

  localparam int DRAIN_CYCLES = FRAC_BITS_DEF + 60;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [EDGE_W-1:0] edge_number_i;
  logic [CELL_W-1:0] cell_x_i, cell_y_i, cell_z_i;
  logic [SMP_W-1:0] value_a_i, value_b_i;
  logic signed [DIFF_W-1:0] diff_ax_i, diff_ay_i, diff_az_i;
  logic signed [DIFF_W-1:0] diff_bx_i, diff_by_i, diff_bz_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [VTX_W-1:0] vertex_x_o, vertex_y_o, vertex_z_o;
  logic signed [NRM_W-1:0] nrm_x_o, nrm_y_o, nrm_z_o;

  int err_cnt, pending, checked;
  bit no_idle;
  bit hold_out;
  logic [ISO_W-1:0] iso_now;

  isosurface_edge_vertex_normal u_dut (.*);

  isosurface_edge_vertex_normal_chk u_chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .in_valid_i, .in_ready_i(in_ready_o), .edge_number_i,
    .cell_x_i, .cell_y_i, .cell_z_i, .value_a_i, .value_b_i,
    .diff_ax_i, .diff_ay_i, .diff_az_i, .diff_bx_i, .diff_by_i, .diff_bz_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .vertex_x_i(vertex_x_o), .vertex_y_i(vertex_y_o), .vertex_z_i(vertex_z_o),
    .nrm_x_i(nrm_x_o), .nrm_y_i(nrm_y_o), .nrm_z_i(nrm_z_o),
    .err_cnt_o(err_cnt), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(8 * 400000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stalls, quiet stretches, one long hold-off
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_out) begin
        out_ready_i = 1'b0;
        repeat (400) @(negedge clk_i);
        hold_out = 1'b0;
      end else begin
        out_ready_i = no_idle || ($urandom_range(0, 99) >= 13);
      end
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    if (idx == REG_ISO) iso_now = data[ISO_W-1:0];
  endtask

  task automatic send_edge(input logic [EDGE_W-1:0] e, input logic [CELL_W-1:0] cx, cy, cz,
                           input logic [SMP_W-1:0] va, vb,
                           input logic [DIFF_W-1:0] dax, day, daz, dbx, dby, dbz);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < 13) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    edge_number_i = e;
    cell_x_i = cx;
    cell_y_i = cy;
    cell_z_i = cz;
    value_a_i = va;
    value_b_i = vb;
    diff_ax_i = dax;
    diff_ay_i = day;
    diff_az_i = daz;
    diff_bx_i = dbx;
    diff_by_i = dby;
    diff_bz_i = dbz;
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // mostly edges that straddle the iso level, the rest arbitrary
  task automatic send_random_edge;
    logic [SMP_W-1:0] lvl, lo, hi;
    logic [EDGE_W-1:0] e;
    logic [CELL_W-1:0] cx, cy, cz;
    logic [DIFF_W-1:0] d [6];
    lvl = iso_now[ISO_W-1:8];
    lo  = SMP_W'($urandom_range(0, lvl));
    hi  = SMP_W'($urandom_range(lvl, 16'hFFFF));
    if ($urandom_range(0, 99) < 30) begin
      lo = SMP_W'($urandom);
      hi = SMP_W'($urandom);
    end
    e  = EDGE_W'($urandom_range(0, 15));
    cx = CELL_W'($urandom);
    cy = CELL_W'($urandom);
    cz = CELL_W'($urandom);
    foreach (d[k]) d[k] = DIFF_W'($urandom);
    if ($urandom_range(0, 1)) send_edge(e, cx, cy, cz, lo, hi,
        d[0], d[1], d[2], d[3], d[4], d[5]);
    else send_edge(e, cx, cy, cz, hi, lo, d[0], d[1], d[2], d[3], d[4], d[5]);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] iso_set  [8];
    logic [CFG_DATA_W-1:0] mask_set [8];
    logic [CFG_DATA_W-1:0] asp_set  [8];
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_ISO;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    edge_number_i = '0;
    cell_x_i = '0;
    cell_y_i = '0;
    cell_z_i = '0;
    value_a_i = '0;
    value_b_i = '0;
    diff_ax_i = '0;
    diff_ay_i = '0;
    diff_az_i = '0;
    diff_bx_i = '0;
    diff_by_i = '0;
    diff_bz_i = '0;
    no_idle = 1'b0;
    hold_out = 1'b0;
    iso_now = ISO_RST;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings, then a mid iso level
    send_edge(4'd0, 10'd0, 10'd0, 10'd0, 16'd0, 16'hFFFF, 17'h0FFFF, 17'h10001,
              17'h10000, 17'h0FFFF, 17'h10001, 17'h10000);
    send_edge(4'd5, 10'h3FF, 10'h3FF, 10'h3FF, 16'h1234, 16'h1234, 17'd0, 17'd0, 17'd0,
              17'd0, 17'd0, 17'd0);
    drain;
    write_reg(REG_ISO, 24'h400080);
    for (int e = 0; e < 16; e++)
      send_edge(EDGE_W'(e), CELL_W'($urandom), CELL_W'($urandom), CELL_W'($urandom),
                16'h3000, 16'h5000, DIFF_W'($urandom), DIFF_W'($urandom),
                DIFF_W'($urandom), DIFF_W'($urandom), DIFF_W'($urandom),
                DIFF_W'($urandom));
    send_edge(4'd9, 10'h3FF, 10'h3FF, 10'h3FF, 16'h5000, 16'h3000, 17'd1, 17'd0, 17'd0,
              17'd0, 17'd0, 17'h1FFFF);
    send_edge(4'd11, 10'd7, 10'd8, 10'd9, 16'h4000, 16'h4000, 17'd5, 17'd0, 17'd0,
              17'd0, 17'd0, 17'd0);
    send_edge(4'd3, 10'd1, 10'd2, 10'd3, 16'h4000, 16'h4001, 17'd0, 17'd0, 17'd0,
              17'd0, 17'd0, 17'd0);
    send_edge(4'd6, 10'd1, 10'd2, 10'd3, 16'h0000, 16'h4000, 17'h10000, 17'h10000,
              17'h10000, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF);
    drain;

    iso_set  = '{24'h000000, 24'hFFFFFF, 24'h800000, 24'h000000, 24'h123456, 24'hABCDEF,
                 24'h7F8000, 24'h010000};
    mask_set = '{24'h00FFFF, 24'h00FFFF, 24'h000000, 24'h00FF00, 24'h00FFFF, 24'h00F0F0,
                 24'h00FFFF, 24'h007FFF};
    asp_set  = '{24'h000100, 24'h00FFFF, 24'h000001, 24'h000000, 24'h000080, 24'h001234,
                 24'h000100, 24'h0000FF};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_ISO, ph < 4 ? iso_set[ph] : CFG_DATA_W'($urandom));
      write_reg(REG_MASK, mask_set[ph]);
      write_reg(REG_ASPECT, asp_set[ph]);
      no_idle  = (ph == 2);
      hold_out = (ph == 4);
      repeat (210) send_random_edge();
      drain;
    end
    no_idle = 1'b0;

    $display("Covered all 16 edge codes, flat edges, zero normals and %0d checked results",
             checked);
    $display("over eight register settings with random and long output stalls.");
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
